// ===== rtl/fcw_pkg.sv =====
// shared constants, codes and types for the text console glyph writer
package fcw_pkg;

  // glyph geometry that is fixed by the 8-bit font byte
  localparam int GLYPH_COLS = 8;

  // defaults for the top-level parameters
  localparam int DEF_GLYPH_ROWS  = 16;
  localparam int DEF_FONT_CHARS  = 256;
  localparam int DEF_CURSOR_BITS = 32;

  // register file geometry
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [2:0] REG_PITCH         = 3'd2;
  localparam logic [2:0] REG_FG_COLOR      = 3'd3;
  localparam logic [2:0] REG_BG_COLOR      = 3'd4;

  localparam logic [14:0] RST_SCREEN_WIDTH  = 15'd1024;
  localparam logic [14:0] RST_SCREEN_HEIGHT = 15'd768;
  localparam logic [15:0] RST_PITCH         = 16'd1024;
  localparam logic [31:0] RST_FG_COLOR      = 32'h00FF_FFFF;
  localparam logic [31:0] RST_BG_COLOR      = 32'h0000_0000;

  // input commands
  localparam logic CMD_WRITE_CHAR = 1'b0;
  localparam logic CMD_LOAD_FONT  = 1'b1;

  // character codes with special handling
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic [14:0] screen_width;
    logic [14:0] screen_height;
    logic [15:0] pitch;
    logic [31:0] fg_color;
    logic [31:0] bg_color;
  } cfg_t;

endpackage

// ===== rtl/text_console_glyph_writer.sv =====
// top level of the text console glyph writer: command decode, cursor, wiring
//
// Input channel (in_valid/in_ready) takes one transaction per item: a font
// byte load (in_command = 1) or a character write (in_command = 0).
// Result channel (out_valid/out_ready) carries one transaction per glyph row:
// the pixel offset of the row start, the column mask clipped to the screen,
// the pixel color and a flag on the final row of the glyph.
// Registers sit behind the APB port at byte address 4*index.
// Font loads and the codes NUL, TAB, LF, VT, FF and CR give no result and
// are taken one per cycle while no glyph is in progress. A drawn glyph (any
// other code, backspace as an erase) first forms the cursor_y * pitch product
// (one 16x16 multiply per cycle), then reads one font row per cycle from the
// font memory while the output is not held; each row passes the font read
// register and the read stage into the output register, and the next item is
// taken only once the last row has left the read stage.
// While a row waits in the output register and out_ready is low, font reads
// pause and rows wait in the one-entry read stage; nothing is dropped.
// Reset clears the cursor to the top left and loads the register defaults;
// the font store is not cleared and must be loaded before use.
module text_console_glyph_writer #(
  parameter int GLYPH_ROWS  = fcw_pkg::DEF_GLYPH_ROWS,
  parameter int FONT_CHARS  = fcw_pkg::DEF_FONT_CHARS,
  parameter int CURSOR_BITS = fcw_pkg::DEF_CURSOR_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_command,
  input  logic [7:0]                  in_char_code,
  input  logic [11:0]                 in_font_index,
  input  logic [7:0]                  in_font_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [63:0]                 out_pixel_offset,
  output logic [7:0]                  out_pixel_mask,
  output logic [31:0]                 out_pixel_color,
  output logic                        out_last_row,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fcw_pkg::PADDR_W-1:0] paddr,
  input  logic [fcw_pkg::PDATA_W-1:0] pwdata,
  output logic [fcw_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int CW    = CURSOR_BITS;
  localparam int DEPTH = FONT_CHARS * GLYPH_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = ((AW > 12) ? AW : 12) + 1;

  fcw_pkg::cfg_t cfg;

  logic [CW-1:0] cur_x_r, cur_x_nxt;
  logic [CW-1:0] cur_y_r, cur_y_nxt;
  logic          accept;
  logic          job_start;
  logic          job_erase;
  logic [CW-1:0] job_x;
  logic [7:0]    job_code;
  logic          render_idle;
  logic [IW-1:0] font_idx;
  logic          font_we;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  assign in_ready = render_idle;
  assign accept   = in_valid && in_ready;

  // loads beyond the font store are dropped
  assign font_idx = IW'(in_font_index);
  assign font_we  = accept && (in_command == fcw_pkg::CMD_LOAD_FONT) &&
                    (font_idx < IW'(DEPTH));

  always_comb begin
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    job_start = 1'b0;
    job_erase = 1'b0;
    job_x     = cur_x_r;
    job_code  = in_char_code;
    if (accept && (in_command == fcw_pkg::CMD_WRITE_CHAR)) begin
      unique case (in_char_code)
        fcw_pkg::CH_NUL: ;
        fcw_pkg::CH_LF: begin
          cur_x_nxt = CW'(fcw_pkg::GLYPH_COLS);
          cur_y_nxt = cur_y_r + CW'(GLYPH_ROWS);
        end
        fcw_pkg::CH_TAB: cur_x_nxt = cur_x_r + CW'(8 * fcw_pkg::GLYPH_COLS);
        fcw_pkg::CH_BS: begin
          // step back, then paint the space glyph in the background color
          cur_x_nxt = cur_x_r - CW'(fcw_pkg::GLYPH_COLS);
          job_x     = cur_x_nxt;
          job_code  = fcw_pkg::CH_SPACE;
          job_erase = 1'b1;
          job_start = 1'b1;
        end
        fcw_pkg::CH_CR: cur_x_nxt = CW'(fcw_pkg::GLYPH_COLS);
        fcw_pkg::CH_FF: cur_y_nxt = cur_y_r + CW'(GLYPH_ROWS);
        fcw_pkg::CH_VT: cur_y_nxt = cur_y_r + CW'(8 * GLYPH_ROWS);
        default: begin
          cur_x_nxt = cur_x_r + CW'(fcw_pkg::GLYPH_COLS);
          job_start = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r <= '0;
      cur_y_r <= '0;
    end else begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
    end
  end

  fcw_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fcw_font_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_font (
    .clk   (clk),
    .we    (font_we),
    .waddr (font_idx[AW-1:0]),
    .wdata (in_font_byte),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  fcw_render #(
    .GLYPH_ROWS  (GLYPH_ROWS),
    .FONT_CHARS  (FONT_CHARS),
    .CURSOR_BITS (CURSOR_BITS),
    .AW          (AW)
  ) u_render (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .job_start        (job_start),
    .job_x            (job_x),
    .job_y            (cur_y_r),
    .job_code         (job_code),
    .job_erase        (job_erase),
    .idle             (render_idle),
    .rd_en            (rd_en),
    .rd_addr          (rd_addr),
    .rd_data          (rd_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_offset (out_pixel_offset),
    .out_pixel_mask   (out_pixel_mask),
    .out_pixel_color  (out_pixel_color),
    .out_last_row     (out_last_row)
  );

  // a font load never lands while a glyph is being read
  a_no_load_during_read: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !font_we)
    else $error("font load overlaps a glyph read");

  // a new glyph starts only once the previous glyph's rows are all issued
  a_start_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    job_start |=> (!out_valid || out_last_row))
    else $error("glyph started with rows of the previous glyph pending");

  // a drawn character holds off the next transaction
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    job_start |=> !in_ready)
    else $error("input taken while a glyph is in progress");

endmodule

// ===== rtl/fcw_cfg_regs.sv =====
// apb register file holding screen geometry, pitch and colors
module fcw_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fcw_pkg::PADDR_W-1:0]  paddr,
  input  logic [fcw_pkg::PDATA_W-1:0]  pwdata,
  output logic [fcw_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output fcw_pkg::cfg_t                cfg
);

  fcw_pkg::cfg_t cfg_r;
  logic [2:0]    reg_idx;
  logic          wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width  <= fcw_pkg::RST_SCREEN_WIDTH;
      cfg_r.screen_height <= fcw_pkg::RST_SCREEN_HEIGHT;
      cfg_r.pitch         <= fcw_pkg::RST_PITCH;
      cfg_r.fg_color      <= fcw_pkg::RST_FG_COLOR;
      cfg_r.bg_color      <= fcw_pkg::RST_BG_COLOR;
    end else if (wr_en) begin
      unique case (reg_idx)
        fcw_pkg::REG_SCREEN_WIDTH:  cfg_r.screen_width  <= pwdata[14:0];
        fcw_pkg::REG_SCREEN_HEIGHT: cfg_r.screen_height <= pwdata[14:0];
        fcw_pkg::REG_PITCH:         cfg_r.pitch         <= pwdata[15:0];
        fcw_pkg::REG_FG_COLOR:      cfg_r.fg_color      <= pwdata;
        fcw_pkg::REG_BG_COLOR:      cfg_r.bg_color      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      fcw_pkg::REG_SCREEN_WIDTH:  prdata = {17'd0, cfg_r.screen_width};
      fcw_pkg::REG_SCREEN_HEIGHT: prdata = {17'd0, cfg_r.screen_height};
      fcw_pkg::REG_PITCH:         prdata = {16'd0, cfg_r.pitch};
      fcw_pkg::REG_FG_COLOR:      prdata = cfg_r.fg_color;
      fcw_pkg::REG_BG_COLOR:      prdata = cfg_r.bg_color;
      default:                    prdata = '0;
    endcase
  end

endmodule

// ===== rtl/fcw_font_mem.sv =====
// font store: one write port, one enabled read port with registered data
module fcw_font_mem #(
  parameter int DEPTH = fcw_pkg::DEF_FONT_CHARS * fcw_pkg::DEF_GLYPH_ROWS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ===== rtl/fcw_render.sv =====
// glyph renderer: offset product, font row reads and the row output register
module fcw_render #(
  parameter int GLYPH_ROWS  = fcw_pkg::DEF_GLYPH_ROWS,
  parameter int FONT_CHARS  = fcw_pkg::DEF_FONT_CHARS,
  parameter int CURSOR_BITS = fcw_pkg::DEF_CURSOR_BITS,
  parameter int AW          = $clog2(FONT_CHARS * GLYPH_ROWS)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  fcw_pkg::cfg_t          cfg,
  input  logic                   job_start,
  input  logic [CURSOR_BITS-1:0] job_x,
  input  logic [CURSOR_BITS-1:0] job_y,
  input  logic [7:0]             job_code,
  input  logic                   job_erase,
  output logic                   idle,
  output logic                   rd_en,
  output logic [AW-1:0]          rd_addr,
  input  logic [7:0]             rd_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [63:0]            out_pixel_offset,
  output logic [7:0]             out_pixel_mask,
  output logic [31:0]            out_pixel_color,
  output logic                   out_last_row
);

  localparam int CW     = CURSOR_BITS;
  localparam int NCHUNK = (CURSOR_BITS + 15) / 16;
  localparam int YW     = NCHUNK * 16;
  localparam int KW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int RW     = $clog2(GLYPH_ROWS + 1);
  localparam int BW     = $clog2(GLYPH_ROWS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_ROWS = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [YW-1:0] ymul_r, ymul_nxt;
  logic [63:0]   off_r, off_nxt;
  logic [RW-1:0] rd_row_r, rd_row_nxt;
  logic [AW-1:0] rd_addr_r, rd_addr_nxt;
  logic          b_valid_r, b_valid_nxt;
  logic [BW-1:0] b_row_r, b_row_nxt;
  logic [7:0]    colmask_r;
  logic [14:0]   rows_left_r;
  logic [31:0]   color_r;

  logic          out_valid_r, out_valid_nxt;
  logic [63:0]   out_offset_r;
  logic [7:0]    out_mask_r;
  logic [31:0]   out_color_r;
  logic          out_last_r;

  logic [CW-1:0] w_ext, h_ext, col_room;
  logic [7:0]    colmask_nxt;
  logic [14:0]   rows_left_nxt;
  logic [8:0]    glyph;
  logic [AW-1:0] glyph_base;
  logic [31:0]   prod;
  logic [63:0]   partial;
  logic          b_adv;
  logic          b_last;
  logic          row_ok;
  logic [7:0]    row_bits;

  assign idle             = (state_r == ST_IDLE);
  assign rd_addr          = rd_addr_r;
  assign out_valid        = out_valid_r;
  assign out_pixel_offset = out_offset_r;
  assign out_pixel_mask   = out_mask_r;
  assign out_pixel_color  = out_color_r;
  assign out_last_row     = out_last_r;

  // clip limits are fixed for the whole glyph
  always_comb begin
    w_ext    = CW'(cfg.screen_width);
    h_ext    = CW'(cfg.screen_height);
    col_room = w_ext - job_x;
    for (int c = 0; c < fcw_pkg::GLYPH_COLS; c++) begin
      colmask_nxt[c] = (job_x < w_ext) && (CW'(c) < col_room);
    end
    rows_left_nxt = (job_y < h_ext) ? 15'(h_ext - job_y) : 15'd0;
    // code below twice the char count when FONT_CHARS >= 128, so one subtract does the modulo
    glyph      = (9'(job_code) >= 9'(FONT_CHARS)) ? 9'(job_code) - 9'(FONT_CHARS)
                                                  : 9'(job_code);
    glyph_base = AW'(glyph) * AW'(GLYPH_ROWS);
  end

  // one 16-bit slice of cursor_y times pitch per cycle
  assign prod    = ymul_r[15:0] * cfg.pitch;
  assign partial = 64'(prod) << {k_r, 4'b0000};

  assign b_adv  = b_valid_r && (!out_valid_r || out_ready);
  assign b_last = (b_row_r == BW'(GLYPH_ROWS - 1));
  assign row_ok = (15'(b_row_r) < rows_left_r);
  assign rd_en  = (state_r == ST_ROWS) && (rd_row_r < RW'(GLYPH_ROWS)) &&
                  (!b_valid_r || b_adv);

  always_comb begin
    for (int c = 0; c < fcw_pkg::GLYPH_COLS; c++) begin
      row_bits[c] = rd_data[7 - c];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    ymul_nxt      = ymul_r;
    off_nxt       = off_r;
    rd_row_nxt    = rd_row_r;
    rd_addr_nxt   = rd_addr_r;
    b_valid_nxt   = b_valid_r;
    b_row_nxt     = b_row_r;
    out_valid_nxt = out_valid_r;

    unique case (state_r)
      ST_IDLE: begin
        if (job_start) begin
          state_nxt   = ST_MUL;
          k_nxt       = '0;
          ymul_nxt    = YW'(job_y);
          off_nxt     = 64'(job_x);
          rd_row_nxt  = '0;
          rd_addr_nxt = glyph_base;
        end
      end
      ST_MUL: begin
        off_nxt  = off_r + partial;
        ymul_nxt = ymul_r >> 16;
        k_nxt    = k_r + KW'(1);
        if (k_r == KW'(NCHUNK - 1)) begin
          state_nxt = ST_ROWS;
        end
      end
      ST_ROWS: begin
        if (b_adv && b_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (rd_en) begin
      rd_row_nxt  = rd_row_r + RW'(1);
      rd_addr_nxt = rd_addr_r + AW'(1);
      b_valid_nxt = 1'b1;
      b_row_nxt   = rd_row_r[BW-1:0];
    end else if (b_adv) begin
      b_valid_nxt = 1'b0;
    end

    if (b_adv) begin
      out_valid_nxt = 1'b1;
      off_nxt       = off_r + 64'(cfg.pitch);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      b_valid_r   <= b_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r       <= k_nxt;
    ymul_r    <= ymul_nxt;
    off_r     <= off_nxt;
    rd_row_r  <= rd_row_nxt;
    rd_addr_r <= rd_addr_nxt;
    b_row_r   <= b_row_nxt;
    if (job_start && idle) begin
      colmask_r   <= colmask_nxt;
      rows_left_r <= rows_left_nxt;
      color_r     <= job_erase ? cfg.bg_color : cfg.fg_color;
    end
    if (b_adv) begin
      out_offset_r <= off_r;
      out_mask_r   <= row_ok ? (row_bits & colmask_r) : 8'd0;
      out_color_r  <= color_r;
      out_last_r   <= b_last;
    end
  end

endmodule

// ===== test/text_console_glyph_writer_tb.sv =====
// testbench for the text console glyph writer: font loads and characters checked row by row
module text_console_glyph_writer_tb;

  localparam int ROWS            = fcw_pkg::DEF_GLYPH_ROWS;
  localparam int COLS            = fcw_pkg::GLYPH_COLS;
  localparam int STORE_DEPTH     = fcw_pkg::DEF_FONT_CHARS * fcw_pkg::DEF_GLYPH_ROWS;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 32;
  localparam int DRAIN_CYCLES    = 24;
  localparam int WATCHDOG_LIMIT  = 4000;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  code;
    logic [11:0] idx;
    logic [7:0]  fbyte;
    logic        typed;
    logic [63:0] off0;
    logic [7:0]  mask;
    logic [31:0] color;
  } console_op_t;

  typedef struct packed {
    logic [63:0] offset;
    logic [7:0]  mask;
    logic [31:0] color;
    logic        last_row;
  } glyph_row_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic                         in_command;
  logic [7:0]                   in_char_code;
  logic [11:0]                  in_font_index;
  logic [7:0]                   in_font_byte;
  logic                         out_valid;
  logic                         out_ready;
  logic [63:0]                  out_pixel_offset;
  logic [7:0]                   out_pixel_mask;
  logic [31:0]                  out_pixel_color;
  logic                         out_last_row;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [fcw_pkg::PADDR_W-1:0]  paddr;
  logic [fcw_pkg::PDATA_W-1:0]  pwdata;
  logic [fcw_pkg::PDATA_W-1:0]  prdata;
  logic                         pready;

  fcw_pkg::cfg_t shadow_cfg;
  logic [31:0]   cur_x;
  logic [31:0]   cur_y;
  logic [7:0]    font_rows [STORE_DEPTH];
  bit            row_loaded [STORE_DEPTH];
  glyph_row_t    pending_rows [$];
  int            mismatches = 0;
  int            idle_cycles = 0;
  bit            steady;
  console_op_t   directed_ops [17];

  text_console_glyph_writer u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_char_code    (in_char_code),
    .in_font_index   (in_font_index),
    .in_font_byte    (in_font_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_offset(out_pixel_offset),
    .out_pixel_mask  (out_pixel_mask),
    .out_pixel_color (out_pixel_color),
    .out_last_row    (out_last_row),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // mostly short gaps, a few long ones, none in steady phases
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // small set of glyphs so font loading stays a minor share of the traffic
  function automatic logic [7:0] pick_code();
    case ($urandom_range(0, 11))
      0:       return 8'hFF;
      1:       return fcw_pkg::CH_SPACE;
      2:       return 8'h41;
      3:       return 8'h80;
      4:       return 8'h7F;
      5:       return 8'h01;
      6:       return 8'h0E;
      7:       return 8'h1F;
      8:       return 8'h5A;
      9:       return 8'hC3;
      10:      return 8'hE7;
      default: return 8'h99;
    endcase
  endfunction

  // screen edge a little beyond the cursor so clipping hits often
  function automatic logic [31:0] limit_near(logic [31:0] pos);
    logic [32:0] lim;
    lim = {1'b0, pos} + 33'($urandom_range(1, 48));
    return (lim > 33'd16384) ? 32'd16384 : lim[31:0];
  endfunction

  function automatic void draw_glyph_rows(logic [7:0] code, logic [31:0] color);
    logic [63:0] x64, y64, w64, h64;
    logic [7:0]  bits;
    glyph_row_t  row;
    int          r, c;
    x64 = 64'(cur_x);
    y64 = 64'(cur_y);
    w64 = 64'(shadow_cfg.screen_width);
    h64 = 64'(shadow_cfg.screen_height);
    for (r = 0; r < ROWS; r++) begin
      bits = font_rows[{code, 4'(r)}];
      row.mask = '0;
      // clip tests done without wrap, as unsigned distances to the edges
      for (c = 0; c < COLS; c++) begin
        if (bits[7-c] && y64 < h64 && 64'(r) < h64 - y64 && x64 < w64 && 64'(c) < w64 - x64)
          row.mask[c] = 1'b1;
      end
      row.offset = (y64 + 64'(r)) * 64'(shadow_cfg.pitch) + x64;
      row.color = color;
      row.last_row = (r == ROWS - 1);
      pending_rows.push_back(row);
    end
  endfunction

  task automatic send_item(input console_op_t op);
    int gap;
    int base;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_command = op.cmd;
    in_char_code = op.code;
    in_font_index = op.idx;
    in_font_byte = op.fbyte;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    if (op.cmd == fcw_pkg::CMD_LOAD_FONT) begin
      font_rows[op.idx] = op.fbyte;
      row_loaded[op.idx] = 1'b1;
    end else begin
      case (op.code)
        fcw_pkg::CH_NUL: ;
        fcw_pkg::CH_LF: begin
          cur_x = 32'(COLS);
          cur_y = cur_y + 32'(ROWS);
        end
        fcw_pkg::CH_CR:  cur_x = 32'(COLS);
        fcw_pkg::CH_TAB: cur_x = cur_x + 32'(8 * COLS);
        fcw_pkg::CH_FF:  cur_y = cur_y + 32'(ROWS);
        fcw_pkg::CH_VT:  cur_y = cur_y + 32'(8 * ROWS);
        fcw_pkg::CH_BS: begin
          cur_x = cur_x - 32'(COLS);
          draw_glyph_rows(fcw_pkg::CH_SPACE, shadow_cfg.bg_color);
        end
        default: begin
          draw_glyph_rows(op.code, shadow_cfg.fg_color);
          cur_x = cur_x + 32'(COLS);
        end
      endcase
    end
    // hand-typed rows replace the prediction of this transaction
    if (op.typed) begin
      base = pending_rows.size() - ROWS;
      for (int r = 0; r < ROWS; r++)
        pending_rows[base + r] = '{op.off0 + 64'(r) * 64'(fcw_pkg::RST_PITCH), op.mask,
                                   op.color, 1'(r == ROWS - 1)};
    end
    @(negedge clk);
  endtask

  // a drawn glyph never reads a font row that was not loaded first
  task automatic send_glyph_op(input console_op_t op);
    console_op_t load_op;
    logic [7:0]  glyph;
    logic        draws;
    case (op.code)
      fcw_pkg::CH_NUL, fcw_pkg::CH_TAB, fcw_pkg::CH_LF, fcw_pkg::CH_VT, fcw_pkg::CH_FF,
      fcw_pkg::CH_CR: draws = 1'b0;
      default: draws = 1'b1;
    endcase
    glyph = (op.code == fcw_pkg::CH_BS) ? fcw_pkg::CH_SPACE : op.code;
    if (op.cmd == fcw_pkg::CMD_WRITE_CHAR && draws) begin
      for (int r = 0; r < ROWS; r++) begin
        if (!row_loaded[{glyph, 4'(r)}]) begin
          load_op = '0;
          load_op.cmd = fcw_pkg::CMD_LOAD_FONT;
          load_op.code = 8'($urandom);
          load_op.idx = {glyph, 4'(r)};
          load_op.fbyte = 8'($urandom);
          send_item(load_op);
        end
      end
    end
    send_item(op);
  endtask

  task automatic reg_write(input logic [2:0] index, input logic [31:0] value);
    paddr = {index, 2'b00};
    pwdata = value;
    pwrite = 1'b1;
    psel = 1'b1;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (index)
      fcw_pkg::REG_SCREEN_WIDTH:  shadow_cfg.screen_width = value[14:0];
      fcw_pkg::REG_SCREEN_HEIGHT: shadow_cfg.screen_height = value[14:0];
      fcw_pkg::REG_PITCH:         shadow_cfg.pitch = value[15:0];
      fcw_pkg::REG_FG_COLOR:      shadow_cfg.fg_color = value;
      fcw_pkg::REG_BG_COLOR:      shadow_cfg.bg_color = value;
      default: ;
    endcase
  endtask

  function automatic void report_mismatch(string field, logic [63:0] expected_val,
                                          logic [63:0] actual_val);
    mismatches++;
    $display("%0t: %s expected %h, got %h", $time, field, expected_val, actual_val);
  endfunction

  always @(posedge clk) begin
    glyph_row_t exp_row;
    if (rst_n && out_valid && out_ready) begin
      if (pending_rows.size() == 0) begin
        mismatches++;
        $display("%0t: pixel_offset expected none, got %h", $time, out_pixel_offset);
      end else begin
        exp_row = pending_rows.pop_front();
        if (out_pixel_offset !== exp_row.offset)
          report_mismatch("pixel_offset", exp_row.offset, out_pixel_offset);
        if (out_pixel_mask !== exp_row.mask)
          report_mismatch("pixel_mask", 64'(exp_row.mask), 64'(out_pixel_mask));
        if (out_pixel_color !== exp_row.color)
          report_mismatch("pixel_color", 64'(exp_row.color), 64'(out_pixel_color));
        if (out_last_row !== exp_row.last_row)
          report_mismatch("last_row", 64'(exp_row.last_row), 64'(out_last_row));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int stall;
    stall = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = (stall == 0);
      if (stall > 0)
        stall--;
      else if ($urandom_range(0, 2) == 0)
        stall = pick_gap();
    end
  end

  initial begin
    console_op_t op;
    int          r;
    logic [31:0] w, h, pitch, fg, bg;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = fcw_pkg::CMD_WRITE_CHAR;
    in_char_code = '0;
    in_font_index = '0;
    in_font_byte = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    shadow_cfg = '{fcw_pkg::RST_SCREEN_WIDTH, fcw_pkg::RST_SCREEN_HEIGHT, fcw_pkg::RST_PITCH,
                   fcw_pkg::RST_FG_COLOR, fcw_pkg::RST_BG_COLOR};
    cur_x = '0;
    cur_y = '0;
    steady = 1'b0;

    directed_ops = '{
      // solid block at the origin right after reset
      '{fcw_pkg::CMD_WRITE_CHAR, 8'hFF, 12'h000, 8'h00, 1'b1, 64'h0, 8'hFF,
        fcw_pkg::RST_FG_COLOR},
      '{fcw_pkg::CMD_WRITE_CHAR, fcw_pkg::CH_NUL, 12'h000, 8'h00, 1'b0, 64'h0, 8'h00, 32'h0},
      // erase back to the origin, then once more: cursor wraps far off screen
      '{fcw_pkg::CMD_WRITE_CHAR, fcw_pkg::CH_BS, 12'h000, 8'h00, 1'b1, 64'h0, 8'h81,
        fcw_pkg::RST_BG_COLOR},
      '{fcw_pkg::CMD_WRITE_CHAR, fcw_pkg::CH_BS, 12'h000, 8'h00, 1'b1, 64'hFFFF_FFF8, 8'h00,
        fcw_pkg::RST_BG_COLOR},
      '{fcw_pkg::CMD_WRITE_CHAR, fcw_pkg::CH_TAB, 12'h000, 8'h00, 1'b0, 64'h0, 8'h00, 32'h0},
      '{fcw_pkg::CMD_WRITE_CHAR, 8'h41, 12'h000, 8'h00, 1'b0, 64'h0, 8'h00, 32'h0},
      '{fcw_pkg::CMD_WRITE_CHAR, fcw_pkg::CH_CR, 12'h000, 8'h00, 1'b0, 64'h0, 8'h00, 32'h0},
      '{fcw_pkg::CMD_WRITE_CHAR, fcw_pkg::CH_LF, 12'h000, 8'h00, 1'b0, 64'h0, 8'h00, 32'h0},
      '{fcw_pkg::CMD_WRITE_CHAR, fcw_pkg::CH_FF, 12'h000, 8'h00, 1'b0, 64'h0, 8'h00, 32'h0},
      '{fcw_pkg::CMD_WRITE_CHAR, fcw_pkg::CH_VT, 12'h000, 8'h00, 1'b0, 64'h0, 8'h00, 32'h0},
      '{fcw_pkg::CMD_WRITE_CHAR, 8'h80, 12'h000, 8'h00, 1'b0, 64'h0, 8'h00, 32'h0},
      '{fcw_pkg::CMD_WRITE_CHAR, 8'h7F, 12'h000, 8'h00, 1'b0, 64'h0, 8'h00, 32'h0},
      // top font address clears the last row of the solid block
      '{fcw_pkg::CMD_LOAD_FONT, 8'hAA, 12'hFFF, 8'h00, 1'b0, 64'h0, 8'h00, 32'h0},
      '{fcw_pkg::CMD_WRITE_CHAR, 8'hFF, 12'h000, 8'h00, 1'b0, 64'h0, 8'h00, 32'h0},
      '{fcw_pkg::CMD_LOAD_FONT, 8'hFF, 12'h000, 8'h5A, 1'b0, 64'h0, 8'h00, 32'h0},
      '{fcw_pkg::CMD_WRITE_CHAR, fcw_pkg::CH_SPACE, 12'h000, 8'h00, 1'b0, 64'h0, 8'h00,
        32'h0},
      '{fcw_pkg::CMD_WRITE_CHAR, 8'h01, 12'h000, 8'h00, 1'b0, 64'h0, 8'h00, 32'h0}
    };

    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // fixed glyphs: solid block for 0xFF, the outermost left and right columns for the space
    for (r = 0; r < ROWS; r++) begin
      op = '0;
      op.cmd = fcw_pkg::CMD_LOAD_FONT;
      op.idx = {8'hFF, 4'(r)};
      op.fbyte = 8'hFF;
      send_item(op);
      op.idx = {fcw_pkg::CH_SPACE, 4'(r)};
      op.fbyte = 8'h81;
      send_item(op);
    end

    foreach (directed_ops[i])
      send_glyph_op(directed_ops[i]);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      in_valid = 1'b0;
      while (pending_rows.size() != 0) @(negedge clk);
      repeat (DRAIN_CYCLES) @(negedge clk);
      steady = (phase % 3 == 2);
      w = limit_near(cur_x);
      h = limit_near(cur_y);
      pitch = $urandom_range(1, 65535);
      fg = $urandom;
      bg = $urandom;
      case (phase)
        0: begin
          w = 32'd1;
          h = 32'd1;
          pitch = 32'd1;
          fg = 32'hFFFF_FFFF;
          bg = 32'hFFFF_FFFF;
        end
        2: begin
          w = 32'd16384;
          h = 32'd16384;
          pitch = 32'd65535;
          fg = 32'h0;
        end
        // zero-sized screen masks everything
        4: begin
          w = 32'd0;
          h = 32'd0;
        end
        default: ;
      endcase
      reg_write(fcw_pkg::REG_SCREEN_WIDTH, w);
      reg_write(fcw_pkg::REG_SCREEN_HEIGHT, h);
      reg_write(fcw_pkg::REG_PITCH, pitch);
      reg_write(fcw_pkg::REG_FG_COLOR, fg);
      reg_write(fcw_pkg::REG_BG_COLOR, bg);

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        r = $urandom_range(0, 99);
        op = '0;
        op.cmd = (r < 10) ? fcw_pkg::CMD_LOAD_FONT : fcw_pkg::CMD_WRITE_CHAR;
        op.code = pick_code();
        // some loads rewrite rows of glyphs that are drawn
        op.idx = (r < 5) ? {pick_code(), 4'($urandom)} : 12'($urandom);
        op.fbyte = 8'($urandom);
        if (r >= 88) op.code = pick_code();
        else if (r >= 85) op.code = fcw_pkg::CH_NUL;
        else if (r >= 83) op.code = fcw_pkg::CH_VT;
        else if (r >= 80) op.code = fcw_pkg::CH_FF;
        else if (r >= 76) op.code = fcw_pkg::CH_TAB;
        else if (r >= 71) op.code = fcw_pkg::CH_LF;
        else if (r >= 66) op.code = fcw_pkg::CH_CR;
        else if (r >= 58) op.code = fcw_pkg::CH_BS;
        send_glyph_op(op);
      end
    end

    in_valid = 1'b0;
    while (pending_rows.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (mismatches == 0 && pending_rows.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
